### hdl/bcd_dd_pkg.sv
package bcd_dd_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 2;
    localparam int SEL_W   = 2;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    localparam logic [CNT_W-1:0] CNT_RESET = 2'd3;

    typedef logic [DIGIT_W-1:0] t_digit;

endpackage

### hdl/bcd_digit_display_driver_unit.sv
// Binary to BCD display driver. Each accepted value runs through a pipeline of
// 2*MAX_DIGITS register stages, a reciprocal multiply and a remainder stage for
// every decimal digit, and lands in an output serialiser that sends one beat per
// digit, most significant shown digit first, with digit_select counting up from
// zero and last_digit on the final beat. With n = min(digit_count, MAX_DIGITS)
// a value gives n beats, and the digit stages keep taking new values while
// the serialiser is busy until back-pressure fills them and o_stall rises.
// A value taken while the count is zero gives no beats. digit_count is to be
// written only while no value is in flight.
module bcd_digit_display_driver_unit
    import bcd_dd_pkg::*;
#(
    parameter int MAX_DIGITS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DIGIT_W-1:0] o_bcd_digit,
    output logic [SEL_W-1:0]   o_digit_select,
    output logic               o_last_digit
);

    localparam int KW = ($clog2(MAX_DIGITS + 1) > 2) ? $clog2(MAX_DIGITS + 1) : 2;
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [KW-1:0] MAX_N = KW'(MAX_DIGITS);

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] t_digit_vec;

    logic [CNT_W-1:0] r_digit_count;

    // multiply stages
    logic               r_m_vld [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_m_xlo [MAX_DIGITS];
    logic [VALUE_W-1:0] r_m_q   [MAX_DIGITS];
    t_digit_vec         r_m_dig [MAX_DIGITS];

    // remainder stages
    logic               r_r_vld [MAX_DIGITS];
    logic [VALUE_W-1:0] r_r_val [MAX_DIGITS];
    t_digit_vec         r_r_dig [MAX_DIGITS];

    // output serialiser
    logic               r_s_vld;
    t_digit_vec         r_s_dig;
    logic [KW-1:0]      r_s_k;

    logic                 w_v_in  [MAX_DIGITS];
    logic [VALUE_W-1:0]   w_x_in  [MAX_DIGITS];
    t_digit_vec           w_d_in  [MAX_DIGITS];
    logic [2*VALUE_W-1:0] w_prod  [MAX_DIGITS];
    logic [VALUE_W-1:0]   n_m_q   [MAX_DIGITS];
    t_digit_vec           n_r_dig [MAX_DIGITS];
    logic                 w_rdy_m [MAX_DIGITS+1];
    logic                 w_rdy_r [MAX_DIGITS];
    logic                 w_rdy_s;
    logic [KW-1:0]        w_n;
    logic                 w_s_last;
    logic [KW-1:0]        w_idx;
    t_digit               w_rem;

    always_comb begin
        if (KW'(r_digit_count) > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = KW'(r_digit_count);
        end
        w_s_last = (r_s_k == w_n - KW'(1));
        w_idx    = w_n - KW'(1) - r_s_k;
    end

    always_comb begin
        w_v_in[0] = i_valid;
        w_x_in[0] = i_value;
        w_d_in[0] = '0;
        for (int j = 1; j < MAX_DIGITS; j++) begin
            w_v_in[j] = r_r_vld[j-1];
            w_x_in[j] = r_r_val[j-1];
            w_d_in[j] = r_r_dig[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_DIGITS; j++) begin
            w_prod[j] = {{VALUE_W{1'b0}}, w_x_in[j]} * {{VALUE_W{1'b0}}, DIV10_RECIP};
            n_m_q[j]  = VALUE_W'(w_prod[j] >> DIV10_SHIFT);
        end
    end

    // only the low nibble of x - 10*q matters, it is the digit itself
    always_comb begin
        w_rem = '0;
        for (int j = 0; j < MAX_DIGITS; j++) begin
            w_rem = r_m_xlo[j] - ({r_m_q[j][0], 3'b000} + {r_m_q[j][2:0], 1'b0});
            n_r_dig[j]    = r_m_dig[j];
            n_r_dig[j][j] = w_rem;
        end
    end

    // backpressure chain, serialiser first
    always_comb begin
        w_rdy_s = !r_s_vld || (!i_stall && w_s_last);
        w_rdy_m[MAX_DIGITS] = w_rdy_s;
        for (int j = MAX_DIGITS - 1; j >= 0; j--) begin
            w_rdy_r[j] = !r_r_vld[j] || w_rdy_m[j+1];
            w_rdy_m[j] = !r_m_vld[j] || w_rdy_r[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= CNT_RESET;
            r_s_vld       <= 1'b0;
            r_s_k         <= '0;
            for (int j = 0; j < MAX_DIGITS; j++) begin
                r_m_vld[j] <= 1'b0;
                r_r_vld[j] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_digit_count <= i_cfg_wdata;
            end
            for (int j = 0; j < MAX_DIGITS; j++) begin
                if (w_rdy_m[j]) begin
                    r_m_vld[j] <= w_v_in[j];
                end
                if (w_rdy_r[j]) begin
                    r_r_vld[j] <= r_m_vld[j];
                end
            end
            // a value with a zero count is dropped here
            if (w_rdy_s) begin
                r_s_vld <= r_r_vld[MAX_DIGITS-1] && (w_n != '0);
                r_s_k   <= '0;
            end else if (!i_stall) begin
                r_s_k <= r_s_k + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if (w_rdy_m[j]) begin
                r_m_xlo[j] <= w_x_in[j][DIGIT_W-1:0];
                r_m_q[j]   <= n_m_q[j];
                r_m_dig[j] <= w_d_in[j];
            end
            if (w_rdy_r[j]) begin
                r_r_val[j] <= r_m_q[j];
                r_r_dig[j] <= n_r_dig[j];
            end
        end
        if (w_rdy_s) begin
            r_s_dig <= r_r_dig[MAX_DIGITS-1];
        end
    end

    assign o_stall        = !w_rdy_m[0];
    assign o_valid        = r_s_vld;
    assign o_bcd_digit    = r_s_dig[w_idx[IW-1:0]];
    assign o_digit_select = r_s_k[SEL_W-1:0];
    assign o_last_digit   = w_s_last;

    a_digit_is_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bcd_digit <= 4'd9))
        else $error("bcd digit out of range");

    a_select_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_digit |=>
            o_valid && (o_digit_select == SEL_W'($past(o_digit_select) + 2'd1)))
        else $error("digit select did not advance by one");

    a_select_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_digit |=> !o_valid || (o_digit_select == '0))
        else $error("new value does not start at digit zero");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_m_vld[0] && r_s_vld)
        else $error("input stalled with room in the pipeline");

endmodule
